/* sv/rdfft_pkg.sv */
// Shared constants, types and helper functions of the radix-2 FFT.
package rdfft_pkg;

   localparam int MAX_LOG   = 10;
   localparam int MAX_N     = 1 << MAX_LOG;
   localparam int SMP_W     = 16;
   localparam int TW_W      = 16;
   localparam int ACC_W     = SMP_W + MAX_LOG;
   localparam int TW_DEPTH  = MAX_N / 4;
   localparam int TW_IDX_W  = MAX_LOG - 2;
   localparam int PROD_W    = ACC_W + TW_W;
   localparam int TSUM_W    = PROD_W + 1;
   localparam int T_W       = TSUM_W - (TW_W - 1);
   localparam int ADR_W     = MAX_LOG;
   localparam int CNT_W     = MAX_LOG + 1;
   localparam int LOG_W     = 4;
   localparam int CSR_AW    = 3;

   localparam logic [CSR_AW-1:0] CSR_SIZE_ADDR = 3'd0;
   localparam logic [LOG_W-1:0]  SIZE_RESET    = 4'd10;

   typedef logic [TW_W+TW_W-1:0] tw_word_type;
   typedef tw_word_type tw_rom_type [TW_DEPTH];

   typedef struct packed {
      logic a_en;
      logic mul_en;
      logic sum_en;
   } bf_ctl_type;

   typedef struct packed {
      logic             wr;
      logic [LOG_W-1:0] size_log2;
   } csr_evt_type;

   // Q2.30 value rounded to Q1.15, clipped to the positive range
   function automatic logic [TW_W-1:0] to_tw(input longint v);
      longint r;
      longint vv;
      vv = (v < 0) ? 64'sd0 : v;
      r  = (vv + (64'sd1 <<< 14)) >>> 15;
      if (r > 32767) r = 32767;
      return r[TW_W-1:0];
   endfunction

   // shift-and-subtract quotient, only evaluated while the table is built
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Quarter-wave table: Taylor series in unsigned Q2.30
   function automatic tw_rom_type build_rom();
      tw_rom_type        rom;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   ts;
      longint unsigned   tc;
      longint            ss;
      longint            cs;
      for (int m = 0; m < TW_DEPTH; m++) begin
         x  = (64'd6746518852 * longint'(m)) >> MAX_LOG;
         x2 = (x * x) >> 30;
         ts = x;
         tc = 64'd1 << 30;
         ss = longint'(x);
         cs = longint'(tc);
         for (int k = 1; k <= 12; k++) begin
            ts = udiv((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = udiv((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if (k[0] == 1'b1) begin
               ss = ss - longint'(ts);
               cs = cs - longint'(tc);
            end else begin
               ss = ss + longint'(ts);
               cs = cs + longint'(tc);
            end
         end
         rom[m] = {to_tw(cs), to_tw(ss)};
      end
      return rom;
   endfunction

   localparam tw_rom_type TW_ROM = build_rom();

   function automatic logic [ADR_W-1:0] bit_rev(input logic [ADR_W-1:0] v);
      logic [ADR_W-1:0] r;
      for (int b = 0; b < ADR_W; b++) r[b] = v[ADR_W-1-b];
      return r;
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [T_W:0] v);
      logic signed [T_W:0] hi;
      logic signed [T_W:0] lo;
      hi = (T_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) return hi[ACC_W-1:0];
      if (v < lo) return lo[ACC_W-1:0];
      return v[ACC_W-1:0];
   endfunction

endpackage

/* sv/rdfft_csr.sv */
// APB register block holding the transform size.
module rdfft_csr
   import rdfft_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output csr_evt_type       evt
);

   logic [LOG_W-1:0] size_ff;
   logic [LOG_W-1:0] size_in;
   logic             hit;

   assign csr_pready = 1'b1;
   assign hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_SIZE_ADDR);
   assign size_in = hit ? csr_pwdata[LOG_W-1:0] : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_SIZE_ADDR) ? {28'd0, size_ff} : 32'd0;
   assign evt.wr = hit;
   assign evt.size_log2 = size_ff;

endmodule

/* sv/rdfft_bfly.sv */
// Butterfly datapath: twiddle lookup, complex multiply, add and subtract.
module rdfft_bfly
   import rdfft_pkg::*;
(
   input  logic                   clock,
   input  bf_ctl_type             ctl,
   input  logic [ADR_W-1:0]       tw_pos,
   input  logic [2*ACC_W-1:0]     rd_data,
   output logic [2*ACC_W-1:0]     sum_data,
   output logic [2*ACC_W-1:0]     dif_data
);

   logic signed [ACC_W-1:0]  a_re_ff, a_im_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [T_W-1:0]    t_re_ff, t_im_ff;
   logic signed [TW_W-1:0]   c_w, s_w, w_re, w_im;
   logic signed [ACC_W-1:0]  b_re, b_im;
   logic signed [TSUM_W-1:0] s_re, s_im;
   logic [1:0]               quad;
   tw_word_type              tw_word;

   assign tw_word = TW_ROM[tw_pos[TW_IDX_W-1:0]];
   assign c_w  = tw_word[2*TW_W-1:TW_W];
   assign s_w  = tw_word[TW_W-1:0];
   assign quad = tw_pos[ADR_W-1:ADR_W-2];

   // base is cos - j*sin, rotated by -j per quadrant
   always_comb begin
      unique case (quad)
         2'd0: begin w_re = c_w;  w_im = -s_w; end
         2'd1: begin w_re = -s_w; w_im = -c_w; end
         2'd2: begin w_re = -c_w; w_im = s_w;  end
         default: begin w_re = s_w; w_im = c_w; end
      endcase
   end

   assign b_re = rd_data[ACC_W-1:0];
   assign b_im = rd_data[2*ACC_W-1:ACC_W];

   always_ff @(posedge clock) begin
      if (ctl.a_en) begin
         a_re_ff <= rd_data[ACC_W-1:0];
         a_im_ff <= rd_data[2*ACC_W-1:ACC_W];
      end
      if (ctl.mul_en) begin
         p_rr_ff <= b_re * w_re;
         p_ii_ff <= b_im * w_im;
         p_ri_ff <= b_re * w_im;
         p_ir_ff <= b_im * w_re;
      end
      if (ctl.sum_en) begin
         t_re_ff <= T_W'(s_re >>> (TW_W - 1));
         t_im_ff <= T_W'(s_im >>> (TW_W - 1));
      end
   end

   assign s_re = TSUM_W'(p_rr_ff) - TSUM_W'(p_ii_ff) + (TSUM_W'(1) <<< (TW_W - 2));
   assign s_im = TSUM_W'(p_ri_ff) + TSUM_W'(p_ir_ff) + (TSUM_W'(1) <<< (TW_W - 2));

   assign sum_data = {sat_acc((T_W+1)'(a_im_ff) + (T_W+1)'(t_im_ff)),
                      sat_acc((T_W+1)'(a_re_ff) + (T_W+1)'(t_re_ff))};
   assign dif_data = {sat_acc((T_W+1)'(a_im_ff) - (T_W+1)'(t_im_ff)),
                      sat_acc((T_W+1)'(a_re_ff) - (T_W+1)'(t_re_ff))};

endmodule

/* sv/radix2_dit_fft.sv */
// Top level: sample memory, load/read/transform sequencer and result register.
//
//  channel | dir | transfer carries
//  req_    | in  | tuser kind, tdata {sample_im, sample_re}
//  rsp_    | out | tuser result_valid, tlast last_bin, tdata {bin_index, im, re}
//  csr_    | in  | APB, size_log2 at address 0
//
// Loads are written in the idle state, reads pass through the output state; the last load
// of a frame starts the transform, one butterfly at a time (read A, read B, multiply, sum,
// write A, write B) through the single-port-read sample memory, during which req_tready is low.
// Samples are stored at bit-reversed addresses, so no reorder pass is needed.
// Synchronous reset clears counters and control; the memory is not cleared.
// A waiting result blocks new transfers only until rsp_tready is seen.
module radix2_dit_fft
   import rdfft_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // sample_re[15:0], sample_im[31:16]
   input  logic              req_tuser,   // kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // result_re[25:0], result_im[51:26], bin_index[61:52]
   output logic              rsp_tuser,   // result_valid
   output logic              rsp_tlast,   // last_bin
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RDA  = 8'b0000_0010,
      S_RDB  = 8'b0000_0100,
      S_MUL  = 8'b0000_1000,
      S_SUM  = 8'b0001_0000,
      S_WRA  = 8'b0010_0000,
      S_WRB  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]   read_cnt_ff, read_cnt_in;
   logic [LOG_W-1:0]   stage_ff, stage_in;
   logic [ADR_W-2:0]   bf_ff, bf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_flag_ff, rsp_flag_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [ADR_W-1:0]   rsp_bin_ff, rsp_bin_in;
   logic [2*ACC_W-1:0] rsp_val_ff, rsp_val_in;

   logic [2*ACC_W-1:0] mem [MAX_N];
   logic [2*ACC_W-1:0] rd_data_ff;
   logic [ADR_W-1:0]   rd_addr, wr_addr;
   logic [2*ACC_W-1:0] wr_data;
   logic               wr_en;

   csr_evt_type        evt;
   bf_ctl_type         bctl;
   logic [2*ACC_W-1:0] sum_data, dif_data;

   logic [LOG_W-1:0]   lg;
   logic [CNT_W-1:0]   n_cnt;
   logic [ADR_W-1:0]   j_mask, j_val, k_a, k_b, b_bit, tw_pos, bf_ext;
   logic [ADR_W-1:0]   ld_idx;
   logic               take, req_ok, last_bf;

   rdfft_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .evt
   );

   rdfft_bfly u_bfly (
      .clock, .ctl(bctl), .tw_pos, .rd_data(rd_data_ff), .sum_data, .dif_data
   );

   always_comb begin
      priority if (evt.size_log2 < 4'd2) lg = 4'd2;
      else if (evt.size_log2 > LOG_W'(MAX_LOG)) lg = LOG_W'(MAX_LOG);
      else lg = evt.size_log2;
   end
   assign n_cnt = CNT_W'(1) << lg;

   // butterfly addressing for stage L = stage_ff, span B = 2^(L-1)
   assign bf_ext  = {1'b0, bf_ff};
   assign b_bit   = ADR_W'(1) << (stage_ff - 4'd1);
   assign j_mask  = b_bit - ADR_W'(1);
   assign j_val   = bf_ext & j_mask;
   assign k_a     = ((bf_ext >> (stage_ff - 4'd1)) << stage_ff) | j_val;
   assign k_b     = k_a | b_bit;
   assign tw_pos  = j_val << (LOG_W'(MAX_LOG) - stage_ff);
   assign last_bf = (bf_ext + ADR_W'(1)) == n_cnt[ADR_W:1];

   assign req_ok     = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = req_ok;
   assign take       = req_tvalid && req_ok;
   assign ld_idx     = (load_cnt_ff >= n_cnt) ? '0 : load_cnt_ff[ADR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      read_cnt_in  = read_cnt_ff;
      stage_in     = stage_ff;
      bf_in        = bf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_val_in   = rsp_val_ff;
      rd_addr      = read_cnt_ff[ADR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = bit_rev(ld_idx) >> (LOG_W'(MAX_LOG) - lg);
      wr_data      = {ACC_W'(signed'(req_tdata[31:16])), ACC_W'(signed'(req_tdata[15:0]))};
      bctl         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take && !req_tuser) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_flag_in  = 1'b0;
               rsp_last_in  = 1'b0;
               rsp_bin_in   = '0;
               rsp_val_in   = '0;
               load_cnt_in  = CNT_W'(ld_idx) + CNT_W'(1);
               read_cnt_in  = '0;
               if (load_cnt_in == n_cnt) begin
                  stage_in = 4'd1;
                  bf_in    = '0;
                  state_in = S_RDA;
               end
            end else if (take) begin
               if (load_cnt_ff == n_cnt) begin
                  state_in = S_OUT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_flag_in  = 1'b0;
                  rsp_last_in  = 1'b0;
                  rsp_bin_in   = '0;
                  rsp_val_in   = '0;
               end
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_flag_in  = 1'b1;
            rsp_val_in   = rd_data_ff;
            rsp_bin_in   = read_cnt_ff[ADR_W-1:0];
            rsp_last_in  = (read_cnt_ff + CNT_W'(1)) == n_cnt;
            read_cnt_in  = read_cnt_ff + CNT_W'(1);
            if (rsp_last_in) begin
               read_cnt_in = '0;
               load_cnt_in = '0;
            end
            state_in = S_IDLE;
         end
         S_RDA: begin
            rd_addr  = k_a;
            state_in = S_RDB;
         end
         S_RDB: begin
            rd_addr    = k_b;
            bctl.a_en  = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            bctl.mul_en = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            bctl.sum_en = 1'b1;
            state_in    = S_WRA;
         end
         S_WRA: begin
            wr_en    = 1'b1;
            wr_addr  = k_a;
            wr_data  = sum_data;
            state_in = S_WRB;
         end
         S_WRB: begin
            wr_en    = 1'b1;
            wr_addr  = k_b;
            wr_data  = dif_data;
            state_in = S_RDA;
            bf_in    = bf_ff + 1'b1;
            if (last_bf) begin
               bf_in = '0;
               if (stage_ff == lg) begin
                  state_in = S_IDLE;
               end else begin
                  stage_in = stage_ff + 4'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (evt.wr) begin
         load_cnt_in = '0;
         read_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         stage_ff     <= 4'd1;
         bf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         read_cnt_ff  <= read_cnt_in;
         stage_ff     <= stage_in;
         bf_ff        <= bf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flag_ff <= rsp_flag_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_val_ff  <= rsp_val_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_bin_ff, rsp_val_ff};

endmodule

/* test/radix2_dit_fft_tb.sv */
// Self-checking stream testbench for the radix-2 FFT: random frames, scoreboard, APB size writes.
`timescale 1ns / 100ps

module radix2_dit_fft_tb;
   import rdfft_pkg::*;

   typedef struct {
      logic              kind;
      logic signed [15:0] re;
      logic signed [15:0] im;
   } sample_item_type;

   typedef struct {
      logic        valid;
      logic [25:0] re;
      logic [25:0] im;
      logic [9:0]  bin;
      logic        last;
   } bin_result_type;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [63:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   radix2_dit_fft dut (.*);

   sample_item_type pending_samples[$];
   bin_result_type  bins_expected[$];
   sample_item_type nxt_item;
   bin_result_type  got_bin;
   bin_result_type  want_bin;

   // predictor state
   longint      fft_re [MAX_N];
   longint      fft_im [MAX_N];
   longint      tw_cos [TW_DEPTH];
   longint      tw_sin [TW_DEPTH];
   int unsigned loads_seen;
   int unsigned reads_done;
   int unsigned size_reg;

   int  req_gap;
   int  rsp_hold;
   bit  pressed;
   int  rsp_seen;
   bit  calm;
   int  errors;
   int  idle_cycles;

   function automatic longint q30_to_q15(longint v);
      longint r;
      if (v < 0) v = 0;
      r = (v + (64'sd1 <<< 14)) >>> 15;
      return (r > 32767) ? 32767 : r;
   endfunction

   // quarter-wave sine/cosine table from a truncated Taylor series
   function automatic void fill_twiddles();
      longint unsigned x, x2, ts, tc;
      longint          ss, cs;
      for (int m = 0; m < TW_DEPTH; m++) begin
         x  = (64'd6746518852 * m) >> MAX_LOG;
         x2 = (x * x) >> 30;
         ts = x;
         tc = 64'd1 << 30;
         ss = x;
         cs = tc;
         for (int k = 1; k <= 12; k++) begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
               ss -= ts;
               cs -= tc;
            end else begin
               ss += ts;
               cs += tc;
            end
         end
         tw_cos[m] = q30_to_q15(cs);
         tw_sin[m] = q30_to_q15(ss);
      end
   endfunction

   function automatic int unsigned eff_log(int unsigned v);
      return (v < 2) ? 2 : ((v > MAX_LOG) ? MAX_LOG : v);
   endfunction

   function automatic longint clip26(longint v);
      longint hi;
      hi = (64'sd1 <<< 25) - 1;
      return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
   endfunction

   function automatic void run_transform(int unsigned lg);
      int unsigned n, r, hb, ql, q, m, idx, p;
      longint      t, wr, wi, br, bi, tr, ti, ar, ai;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
         if (i < r) begin
            t = fft_re[i]; fft_re[i] = fft_re[r]; fft_re[r] = t;
            t = fft_im[i]; fft_im[i] = fft_im[r]; fft_im[r] = t;
         end
      end
      ql = lg - 2;
      for (int s = 1; s <= lg; s++) begin
         hb = 1 << (s - 1);
         for (int j = 0; j < hb; j++) begin
            p   = j << (lg - s);
            m   = p & ((1 << ql) - 1);
            q   = (p >> ql) & 3;
            idx = (m << (MAX_LOG - lg)) & (TW_DEPTH - 1);
            wr  = tw_cos[idx];
            wi  = -tw_sin[idx];
            // rotate the base twiddle by -j per quadrant
            case (q)
               1: begin t = wr; wr = wi; wi = -t; end
               2: begin wr = -wr; wi = -wi; end
               3: begin t = wr; wr = -wi; wi = t; end
               default: ;
            endcase
            for (int k = j; k < n; k += 2 * hb) begin
               br = fft_re[k + hb];
               bi = fft_im[k + hb];
               tr = (br * wr - bi * wi + (64'sd1 <<< 14)) >>> 15;
               ti = (br * wi + bi * wr + (64'sd1 <<< 14)) >>> 15;
               ar = fft_re[k];
               ai = fft_im[k];
               fft_re[k + hb] = clip26(ar - tr);
               fft_im[k + hb] = clip26(ai - ti);
               fft_re[k]      = clip26(ar + tr);
               fft_im[k]      = clip26(ai + ti);
            end
         end
      end
   endfunction

   function automatic bin_result_type predict_bin(sample_item_type it);
      bin_result_type res;
      int unsigned lg, n;
      lg  = eff_log(size_reg);
      n   = 1 << lg;
      res = '{1'b0, '0, '0, '0, 1'b0};
      if (it.kind == KIND_LOAD) begin
         if (loads_seen >= n) begin
            loads_seen = 0;
            reads_done = 0;
         end
         fft_re[loads_seen] = it.re;
         fft_im[loads_seen] = it.im;
         loads_seen++;
         if (loads_seen == n) begin
            run_transform(lg);
            reads_done = 0;
         end
      end else if (loads_seen == n && reads_done < n) begin
         res.valid = 1'b1;
         res.re    = fft_re[reads_done][25:0];
         res.im    = fft_im[reads_done][25:0];
         res.bin   = reads_done[9:0];
         res.last  = (reads_done == n - 1);
         reads_done++;
         if (reads_done == n) begin
            loads_seen = 0;
            reads_done = 0;
         end
      end
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= 1'b0;
         req_tdata  <= '0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            nxt_item = pending_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt_item.kind;
            req_tdata  <= {nxt_item.im, nxt_item.re};
            if (!calm && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 10);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
         pressed    <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!pressed && rsp_seen >= 40) begin
         pressed    <= 1'b1;
         rsp_hold   <= 400;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_hold   <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            bins_expected.push_back(predict_bin('{req_tuser, req_tdata[15:0], req_tdata[31:16]}));
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            got_bin = '{rsp_tuser, rsp_tdata[25:0], rsp_tdata[51:26], rsp_tdata[61:52], rsp_tlast};
            if (bins_expected.size() == 0) begin
               $error("unexpected transfer on result channel");
               errors++;
            end else begin
               want_bin = bins_expected.pop_front();
               if (got_bin.valid !== want_bin.valid) begin
                  $error("result_valid: expected %0d actual %0d", want_bin.valid, got_bin.valid);
                  errors++;
               end
               if (got_bin.re !== want_bin.re) begin
                  $error("result_re: expected %0d actual %0d",
                         $signed(want_bin.re), $signed(got_bin.re));
                  errors++;
               end
               if (got_bin.im !== want_bin.im) begin
                  $error("result_im: expected %0d actual %0d",
                         $signed(want_bin.im), $signed(got_bin.im));
                  errors++;
               end
               if (got_bin.bin !== want_bin.bin) begin
                  $error("bin_index: expected %0d actual %0d", want_bin.bin, got_bin.bin);
                  errors++;
               end
               if (got_bin.last !== want_bin.last) begin
                  $error("last_bin: expected %0d actual %0d", want_bin.last, got_bin.last);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic write_size(logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_SIZE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      size_reg   = value & 15;
      loads_seen = 0;
      reads_done = 0;
   endtask

   task automatic push_item(logic kind, logic signed [15:0] re, logic signed [15:0] im);
      pending_samples.push_back('{kind, re, im});
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // drain, then let any transform still running finish
   task automatic settle();
      int unsigned lg;
      while (pending_samples.size() > 0 || req_tvalid || bins_expected.size() > 0)
         @(posedge clock);
      lg = eff_log(size_reg);
      repeat (3 * (1 << lg) * lg + 50) @(posedge clock);
   endtask

   initial begin
      int unsigned lg, n, nrd, total;
      logic signed [15:0] xv;
      errors = 0;
      rsp_seen = 0;
      calm = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fill_twiddles();
      for (int i = 0; i < MAX_N; i++) begin
         fft_re[i] = 0;
         fft_im[i] = 0;
      end
      size_reg = SIZE_RESET;
      loads_seen = 0;
      reads_done = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // size 0 clamps to length 4
      write_size(0);
      push_item(KIND_READ, 0, 0);                 // read with no transform done
      push_item(KIND_LOAD, 16'sh7fff, 16'sh7fff);
      push_item(KIND_LOAD, 16'sh8000, 16'sh8000);
      push_item(KIND_LOAD, 16'sh7fff, 16'sh8000);
      push_item(KIND_LOAD, 16'sh8000, 16'sh7fff);
      push_item(KIND_READ, 0, 0);
      push_item(KIND_READ, 0, 0);
      // load with bins still unread starts a fresh frame
      for (int i = 0; i < 4; i++) push_item(KIND_LOAD, pick_sample(), pick_sample());
      for (int i = 0; i < 5; i++) push_item(KIND_READ, 0, 0);
      settle();

      // size 15 clamps to 1024: four loads leave the frame open, so the read is idle
      write_size(32'hffff_fff5 | 32'hf);
      for (int i = 0; i < 4; i++) push_item(KIND_LOAD, pick_sample(), pick_sample());
      push_item(KIND_READ, 0, 0);
      settle();

      // length 512 with full-scale input for maximum growth
      write_size(9);
      for (int i = 0; i < 512; i++) begin
         xv = (i % 3 == 0) ? 16'sh8000 : 16'sh7fff;
         push_item(KIND_LOAD, xv, (i % 2) ? 16'sh8000 : xv);
      end
      for (int i = 0; i < 64; i++) push_item(KIND_READ, 0, 0);
      settle();
      write_size(10);
      write_size(2);

      total = 598;
      while (total < 950) begin
         if ($urandom_range(0, 3) == 0) begin
            settle();
            write_size({$urandom_range(0, 1) ? 28'h0 : 28'($urandom), 4'($urandom_range(0, 6))});
         end
         if (total > 800) calm = 1'b1;
         lg = eff_log(size_reg);
         n  = 1 << lg;
         if ($urandom_range(0, 9) == 0) begin
            push_item(KIND_READ, 16'($urandom), 16'($urandom));
            total++;
         end
         for (int i = 0; i < n; i++) push_item(KIND_LOAD, pick_sample(), pick_sample());
         case ($urandom_range(0, 9))
            0, 1: nrd = $urandom_range(0, n - 1);
            2:    nrd = n + $urandom_range(1, 3);
            default: nrd = n;
         endcase
         for (int i = 0; i < nrd; i++) push_item(KIND_READ, 16'($urandom), 16'($urandom));
         total += n + nrd;
      end

      while (pending_samples.size() > 0 || req_tvalid || bins_expected.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && bins_expected.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
